[src/sharpen_conv3x3_abs_core_assert.svh]
// Assertion macros shared by the sharpen filter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SHARPEN_CONV3X3_ABS_CORE_ASSERT_SVH
`define SHARPEN_CONV3X3_ABS_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SC3_ASSERT_NOW(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SC3_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sc3_pkg.sv]
// Shared types and constants of the 3x3 sharpen filter.
// No dependencies; imported by sc3_pos, sc3_win, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package sc3_pkg;

  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int FILTERED_W   = 11;
  localparam int OUT_TDATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

  typedef struct packed {
    logic emit;
    logic last;
    logic has_up;
    logic has_down;
    logic has_left;
    logic has_right;
  } pos_flags_t;

endpackage

`default_nettype wire

[src/sc3_ram.sv]
// Simple dual-port line store: one write and one registered read per cycle.
// Depends on nothing; used twice by the top level.
`timescale 1ns / 1ps
`default_nettype none

module sc3_ram #(
  parameter int DEPTH = 2048,
  parameter int DATA_W = 8,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/sc3_pos.sv]
// Frame position tracking: input and output counters, frame size registers.
// Depends on sc3_pkg; produces the column and edge flags of each transfer.
`timescale 1ns / 1ps
`default_nettype none

module sc3_pos
  import sc3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int CW = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   take,
  output logic [CW-1:0]          col,
  output pos_flags_t             flags
);

  function automatic logic [CW-1:0] width_last(input logic [WIDTH_REG_W-1:0] raw);
    logic [31:0] r;
    r = 32'(raw);
    if (r == 32'd0) return '0;
    if (r > 32'(MAX_WIDTH)) return CW'(MAX_WIDTH - 1);
    return CW'(r - 32'd1);
  endfunction

  logic [CW-1:0]           w_last;
  logic [HEIGHT_REG_W-1:0] h_last;
  logic [CW-1:0]           in_col;
  logic [HEIGHT_REG_W-1:0] in_row;
  logic [CW-1:0]           out_col;
  logic [HEIGHT_REG_W-1:0] out_row;
  logic                    col_wrap;
  logic                    out_wrap;

  always_comb begin
    col = (in_col > w_last) ? '0 : in_col;
    col_wrap = (col == w_last);
    out_wrap = (out_col >= w_last);
    flags.emit = (in_row >= 16'd2) || ((in_row == 16'd1) && (col != '0));
    flags.last = out_wrap && (out_row >= h_last);
    flags.has_up = (out_row != '0);
    flags.has_down = (out_row < h_last);
    flags.has_left = (out_col != '0);
    flags.has_right = (out_col < w_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= width_last(WIDTH_RESET);
      h_last <= HEIGHT_RESET - 16'd1;
      in_col <= '0;
      in_row <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          w_last <= width_last(cfg_data[WIDTH_REG_W-1:0]);
        end
        CFG_IMAGE_HEIGHT: begin
          h_last <= (cfg_data == '0) ? '0 : cfg_data - 16'd1;
        end
        default: begin
        end
      endcase
      in_col <= '0;
      in_row <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (take) begin
      if (flags.emit && flags.last) begin
        in_col <= '0;
        in_row <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (col_wrap) begin
          in_col <= '0;
          if (in_row != 16'hFFFF) begin
            in_row <= in_row + 16'd1;
          end
        end else begin
          in_col <= col + CW'(1);
        end
        if (flags.emit) begin
          if (out_wrap) begin
            out_col <= '0;
            out_row <= out_row + 16'd1;
          end else begin
            out_col <= out_col + CW'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/sc3_win.sv]
// 3x3 window registers and the sharpen kernel with absolute value.
// Depends on sc3_pkg; the result is combinational from the window state, mid and the flags.
`timescale 1ns / 1ps
`default_nettype none

module sc3_win
  import sc3_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  logic [PIXEL_BITS-1:0] top,
  input  logic [PIXEL_BITS-1:0] mid,
  input  logic [PIXEL_BITS-1:0] bot,
  input  pos_flags_t            flags,
  output logic [FILTERED_W-1:0] filtered
);

  localparam int SW = (PIXEL_BITS + 4 > FILTERED_W + 1) ? PIXEL_BITS + 4 : FILTERED_W + 1;

  logic [PIXEL_BITS-1:0] col2 [3];
  logic [PIXEL_BITS-1:0] col1_mid;
  logic [SW-1:0]         centre;
  logic [SW-1:0]         sum;
  logic [SW-1:0]         mag;

  always_comb begin
    centre = SW'(col2[1]);
    sum = (centre << 2) + centre;
    if (flags.has_up) sum = sum - SW'(col2[0]);
    if (flags.has_down) sum = sum - SW'(col2[2]);
    if (flags.has_left) sum = sum - SW'(col1_mid);
    if (flags.has_right) sum = sum - SW'(mid);
    mag = sum[SW-1] ? (~sum + SW'(1)) : sum;
    filtered = mag[FILTERED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col2[0] <= '0;
      col2[1] <= '0;
      col2[2] <= '0;
      col1_mid <= '0;
    end else if (shift) begin
      col1_mid <= col2[1];
      col2[0] <= top;
      col2[1] <= mid;
      col2[2] <= bot;
    end
  end

endmodule

`default_nettype wire

[src/sharpen_conv3x3_abs_core.sv]
// Sharpen filter user notes: the block takes one pixel transfer per clock as long as no
// result waits on m_axis_tready, which stalls the input; the line stores are two block
// memories, each read once and written once per cycle, and each input transfer passes
// the single memory read stage and then the result register. Results trail the frame
// by one row plus one pixel, so after the last pixel the host sends image_width + 1
// flush transfers to drain them. Writing either size register restarts the frame.
// Depends on sc3_pkg, sc3_pos, sc3_ram, sc3_win and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "sharpen_conv3x3_abs_core_assert.svh"

module sharpen_conv3x3_abs_core
  import sc3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int PIXEL_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [CFG_INDEX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]   s_axis_tdata,  // pixel
  input  logic                              s_axis_tuser,  // flush
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [OUT_TDATA_W-1:0]            m_axis_tdata,  // filtered
  output logic                              m_axis_tlast
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                  take;
  logic [CW-1:0]         col;
  pos_flags_t            flags;
  logic [PIXEL_BITS-1:0] pix;

  logic                  s1_valid;
  logic                  s1_adv;
  logic [CW-1:0]         s1_col;
  logic [PIXEL_BITS-1:0] s1_v;
  pos_flags_t            s1_flags;
  logic                  s1_fwd;
  logic [PIXEL_BITS-1:0] fwd_top;
  logic [PIXEL_BITS-1:0] fwd_mid;
  logic [PIXEL_BITS-1:0] rd_upper;
  logic [PIXEL_BITS-1:0] rd_middle;
  logic [PIXEL_BITS-1:0] top_eff;
  logic [PIXEL_BITS-1:0] mid_eff;
  logic [FILTERED_W-1:0] filtered_next;

  logic                  out_valid;
  logic [FILTERED_W-1:0] out_data;
  logic                  out_last;

  assign pix = s_axis_tuser ? '0 : s_axis_tdata[PIXEL_BITS-1:0];
  assign s1_adv = s1_valid && (!s1_flags.emit || !out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign take = s_axis_tvalid && s_axis_tready;
  assign top_eff = s1_fwd ? fwd_top : rd_upper;
  assign mid_eff = s1_fwd ? fwd_mid : rd_middle;

  sc3_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .col       (col),
    .flags     (flags)
  );

  sc3_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS),
    .ADDR_W (CW)
  ) u_upper (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (mid_eff),
    .re    (take),
    .raddr (col),
    .rdata (rd_upper)
  );

  sc3_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS),
    .ADDR_W (CW)
  ) u_middle (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (s1_v),
    .re    (take),
    .raddr (col),
    .rdata (rd_middle)
  );

  sc3_win #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_win (
    .clk      (clk),
    .rst      (rst),
    .shift    (s1_adv),
    .top      (top_eff),
    .mid      (mid_eff),
    .bot      (s1_v),
    .flags    (s1_flags),
    .filtered (filtered_next)
  );

  // Same-column back-to-back transfers read the store before the older write lands.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
      s1_fwd <= s1_adv && (s1_col == col);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_col <= col;
      s1_v <= pix;
      s1_flags <= flags;
      fwd_top <= mid_eff;
      fwd_mid <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_flags.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags.emit) begin
      out_data <= filtered_next;
      out_last <= s1_flags.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = OUT_TDATA_W'(out_data);
  assign m_axis_tlast = out_last;

  `SC3_ASSERT_NEXT(a_stall_holds, clk, rst, s1_valid && !s1_adv,
    s1_valid && $stable(s1_col), "stalled read stage lost its item")
  `SC3_ASSERT_NEXT(a_result_lands, clk, rst, s1_adv && s1_flags.emit,
    m_axis_tvalid, "result of an advancing item did not reach the output")
  `SC3_ASSERT_NOW(a_fwd_same_col, clk, rst, s1_valid && s1_fwd,
    s1_col == $past(s1_col), "forwarding set for a different column")
  `SC3_ASSERT_NOW(a_ready_only_busy, clk, rst, !s_axis_tready,
    s1_valid && s1_flags.emit && out_valid, "input held off without a blocked result")

endmodule

`default_nettype wire

[bench/tb_sharpen_conv3x3_abs_core.sv]
// Self-checking testbench for sharpen_conv3x3_abs_core: directed frames, then random frames.
// Each filtered pixel is checked against an in-bench model of the 3x3 sharpen window, or a typed directed value.
// Depends on sc3_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_sharpen_conv3x3_abs_core;
  import sc3_pkg::*;

  localparam int MAX_W = 2048;

  typedef struct packed {
    logic [FILTERED_W-1:0] filtered;
    logic                  frame_end;
  } px_result_t;

  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic                  flush;
    logic [15:0]           data;
    logic                  typed;
    logic [FILTERED_W-1:0] filt;
    logic                  last;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;  // pixel
  logic                   s_axis_tuser;  // flush
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // filtered
  logic                   m_axis_tlast;

  logic                   typed_on;
  logic [FILTERED_W-1:0]  typed_filt;
  logic                   typed_last;

  int gap_pct = 0;
  int stall_pct = 0;
  int fails = 0;
  int n_checked = 0;
  int n_items = 0;
  int n_frames = 0;
  int n_regs = 0;
  int phase_pos = 0;
  int cur_w;
  int cur_h;

  // Bench copy of the filter state.
  logic [7:0]        row_above [MAX_W];
  logic [7:0]        row_prev [MAX_W];
  logic [7:0]        win [3][3];
  logic [11:0]       width_reg;
  logic [15:0]       height_reg;
  int                col_in, row_in, col_out, row_out;
  px_result_t        owed_pixels [$];
  px_result_t        head;
  stim_row_t         dir_rows [23];

  sharpen_conv3x3_abs_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic restart_counts();
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
  endtask

  task automatic sharpen_advance(input logic [7:0] px, input logic fl);
    int w, h, c, sum;
    logic [7:0] v, top, mid;
    bit emit, at_end;
    px_result_t r;
    w = (width_reg == 0) ? 1 : ((int'(width_reg) > MAX_W) ? MAX_W : int'(width_reg));
    h = (height_reg == 0) ? 1 : int'(height_reg);
    v = fl ? 8'd0 : px;
    c = (col_in >= w) ? 0 : col_in;
    top = row_above[c];
    mid = row_prev[c];
    row_above[c] = mid;
    row_prev[c] = v;
    for (int k = 0; k < 3; k++) begin
      win[0][k] = win[1][k];
      win[1][k] = win[2][k];
    end
    win[2][0] = top;
    win[2][1] = mid;
    win[2][2] = v;
    emit = (row_in >= 2) || (row_in == 1 && c >= 1);
    if (c + 1 >= w) begin
      col_in = 0;
      if (row_in < 65535) row_in++;
    end else begin
      col_in = c + 1;
    end
    if (emit) begin
      sum = 5 * int'(win[1][1]);
      if (row_out > 0) sum -= int'(win[1][0]);
      if (row_out + 1 < h) sum -= int'(win[1][2]);
      if (col_out > 0) sum -= int'(win[0][1]);
      if (col_out + 1 < w) sum -= int'(win[2][1]);
      if (sum < 0) sum = -sum;
      at_end = (col_out + 1 >= w) && (row_out + 1 >= h);
      r.filtered = sum[FILTERED_W-1:0];
      r.frame_end = at_end;
      if (typed_on) begin
        r.filtered = typed_filt;
        r.frame_end = typed_last;
      end
      owed_pixels.push_back(r);
      if (at_end) begin
        restart_counts();
      end else if (col_out + 1 >= w) begin
        col_out = 0;
        row_out++;
      end else begin
        col_out++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      restart_counts();
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win[i][j] = 8'd0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_pixels.size() == 0) begin
          $error("result transfer with nothing owed: filtered %0d, frame_end %0b",
                 m_axis_tdata[FILTERED_W-1:0], m_axis_tlast);
          fails++;
        end else begin
          head = owed_pixels.pop_front();
          n_checked++;
          if (m_axis_tdata[FILTERED_W-1:0] !== head.filtered) begin
            $error("filtered: expected %0d, got %0d", head.filtered,
                   m_axis_tdata[FILTERED_W-1:0]);
            fails++;
          end
          if (m_axis_tlast !== head.frame_end) begin
            $error("frame_end: expected %0b, got %0b", head.frame_end, m_axis_tlast);
            fails++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_IMAGE_WIDTH) width_reg = cfg_data[WIDTH_REG_W-1:0];
        else height_reg = cfg_data;
        restart_counts();
      end
      if (s_axis_tvalid && s_axis_tready) sharpen_advance(s_axis_tdata, s_axis_tuser);
    end
  end

  task automatic send_item(input logic [7:0] px, input logic fl);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    s_axis_tuser <= fl;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Holds the input off until every owed result has come, then lets the pipeline empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (owed_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_regs++;
  endtask

  task automatic set_size(input logic [15:0] wd, input logic [15:0] hd);
    settle();
    put_reg(CFG_IMAGE_WIDTH, wd);
    put_reg(CFG_IMAGE_HEIGHT, hd);
    cur_w = (wd[11:0] == 0) ? 1 : ((int'(wd[11:0]) > MAX_W) ? MAX_W : int'(wd[11:0]));
    cur_h = (hd == 0) ? 1 : int'(hd);
  endtask

  function automatic logic [7:0] rand_px();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(255));
  endfunction

  // A broken frame ends with a random number, from 0 to 2 * w + 2, of drain transfers.
  task automatic run_frame(input int w, input int h, input bit broken);
    int n_drain;
    n_drain = broken ? $urandom_range(0, 2 * w + 2) : w + 1;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(299) == 0 || (n_frames == 0 && i == w * h / 2)) settle();
      send_item(rand_px(), $urandom_range(29) == 0);
      n_items++;
      phase_pos++;
    end
    for (int i = 0; i < n_drain; i++) begin
      send_item(rand_px(), $urandom_range(7) != 0);
    end
    n_frames++;
  endtask

  initial begin
    #(10_000_000);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    typed_on = 1'b0;
    typed_filt = '0;
    typed_last = 1'b0;

    // A 3x2 frame of extremes, with a flush inside the frame and a pixel in the drain,
    // then 1x1 frames with out-of-range sizes.
    dir_rows = '{
      '{ROW_REG,  CFG_IMAGE_WIDTH,  1'b0, 16'hF003, 1'b0, 11'd0,    1'b0},
      '{ROW_REG,  CFG_IMAGE_HEIGHT, 1'b0, 16'd2,    1'b0, 11'd0,    1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b0, 16'd255,  1'b0, 11'd0,    1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b0, 16'd0,    1'b0, 11'd0,    1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b0, 16'd255,  1'b0, 11'd0,    1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b1, 16'h00AA, 1'b0, 11'd0,    1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b0, 16'd255,  1'b1, 11'd1275, 1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b0, 16'd0,    1'b1, 11'd765,  1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b1, 16'd0,    1'b1, 11'd1275, 1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b0, 16'h005A, 1'b1, 11'd510,  1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b1, 16'd0,    1'b1, 11'd1275, 1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b1, 16'd0,    1'b1, 11'd510,  1'b1},
      '{ROW_REG,  CFG_IMAGE_WIDTH,  1'b0, 16'd0,    1'b0, 11'd0,    1'b0},
      '{ROW_REG,  CFG_IMAGE_HEIGHT, 1'b0, 16'd0,    1'b0, 11'd0,    1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b0, 16'd200,  1'b0, 11'd0,    1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b1, 16'd0,    1'b0, 11'd0,    1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b1, 16'd0,    1'b1, 11'd1000, 1'b1},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b0, 16'd255,  1'b0, 11'd0,    1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b0, 16'h0033, 1'b0, 11'd0,    1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b1, 16'd0,    1'b1, 11'd1275, 1'b1},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b0, 16'd0,    1'b0, 11'd0,    1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b1, 16'd0,    1'b0, 11'd0,    1'b0},
      '{ROW_ITEM, CFG_IMAGE_WIDTH,  1'b1, 16'd0,    1'b1, 11'd0,    1'b1}
    };

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        settle();
        put_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        typed_on <= dir_rows[i].typed;
        typed_filt <= dir_rows[i].filt;
        typed_last <= dir_rows[i].last;
        send_item(dir_rows[i].data[7:0], dir_rows[i].flush);
        n_items++;
      end
    end
    typed_on <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 87 : (ph == 3) ? 33 : 0;
      stall_pct = (ph == 2) ? 87 : (ph == 3) ? 33 : 0;
      phase_pos = 0;
      if (ph == 0) begin
        // The widest and the tallest frames are only started; the next register
        // write restarts each of them.
        set_size(16'hFFFF, 16'd1);
        repeat (30) send_item(rand_px(), $urandom_range(9) == 0);
        n_items += 30;
        set_size(16'd2, 16'hFFFF);
        repeat (30) send_item(rand_px(), $urandom_range(9) == 0);
        n_items += 30;
      end
      while (phase_pos < 300) begin
        r = $urandom_range(99);
        cur_w = (r < 5) ? 0 : (r < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        r = $urandom_range(99);
        cur_h = (r < 5) ? 0 : (r < 85) ? $urandom_range(1, 6) : $urandom_range(7, 16);
        set_size({4'($urandom_range(15)), 12'(cur_w)}, 16'(cur_h));
        repeat ($urandom_range(1, 3)) run_frame(cur_w, cur_h, $urandom_range(9) == 0);
      end
    end

    settle();
    repeat (16) @(negedge clk);
    $display("Checked %0d filtered pixels from %0d pixel transfers in %0d frames,",
             n_checked, n_items, n_frames);
    $display("with %0d register writes and four idle patterns on the two streams.", n_regs);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sharpen_conv3x3_abs_core.f]
+incdir+src
src/sc3_pkg.sv
src/sc3_ram.sv
src/sc3_pos.sv
src/sc3_win.sv
src/sharpen_conv3x3_abs_core.sv
bench/tb_sharpen_conv3x3_abs_core.sv
